/* sv/fsfl_pkg.sv */
`timescale 1ns / 1ps

package fsfl_pkg;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int OFF_IN_W  = 24;
  localparam int OFFSET_W  = 20;
  localparam int COUNT_W   = 9;
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_PAD   = 8;
  localparam int COUNT_RST = 256;
  localparam int SIZE_RST  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_ALLOC_ZERO = 2'd1,
    CMD_FREE       = 2'd2,
    CMD_RESET      = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_INVALID   = 2'd2
  } stat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT = 1'b0,
    REG_SLOT_SIZE  = 1'b1
  } reg_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_RELINK,
    ST_IDLE,
    ST_ALLOC_WAIT,
    ST_FREE_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } alu_rsp_t;

endpackage

/* sv/fsfl_ram.sv */
`timescale 1ns / 1ps

module fsfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fsfl_alu.sv */
`timescale 1ns / 1ps

module fsfl_alu #(
  parameter int unsigned PAD_W = 13,
  parameter int unsigned IDX_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsfl_pkg::alu_req_t         req_i,
  input  logic [PAD_W-1:0]           pad_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [fsfl_pkg::OFF_IN_W-1:0] dividend_i,
  output fsfl_pkg::alu_rsp_t         rsp_o,
  output logic [fsfl_pkg::OFFSET_W-1:0] product_o,
  output logic [fsfl_pkg::OFF_IN_W-1:0] quot_o
);

  import fsfl_pkg::*;

  localparam int unsigned ALU_W = (PAD_W + 1 > OFFSET_W) ? PAD_W + 1 : OFFSET_W;
  localparam int unsigned CNT_W = $clog2(OFF_IN_W);

  logic [ALU_W-1:0]    acc_q, acc_d;
  logic [OFF_IN_W-1:0] opnd_q, opnd_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                busy_q, busy_d;
  alu_op_e             op_q, op_d;

  logic                msb;
  logic [ALU_W-1:0]    shifted;
  logic [ALU_W-1:0]    operand;
  logic [ALU_W:0]      sum;
  logic                borrow;
  logic                last;

  always_comb begin
    msb     = opnd_q[OFF_IN_W-1];
    shifted = {acc_q[ALU_W-2:0], (op_q == ALU_DIV) & msb};
    operand = {{(ALU_W-PAD_W){1'b0}}, pad_i};
    if (op_q == ALU_DIV) begin
      sum = {1'b0, shifted} - {1'b0, operand};
    end else begin
      sum = {1'b0, shifted} + {1'b0, operand};
    end
    borrow = sum[ALU_W];
    if (op_q == ALU_DIV) begin
      last = (cnt_q == CNT_W'(OFF_IN_W - 1));
    end else begin
      last = (cnt_q == CNT_W'(IDX_W - 1));
    end
  end

  always_comb begin
    acc_d  = acc_q;
    opnd_d = opnd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    if (req_i.start) begin
      op_d   = req_i.op;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      if (req_i.op == ALU_DIV) begin
        opnd_d = dividend_i;
      end else begin
        opnd_d = {idx_i, {(OFF_IN_W-IDX_W){1'b0}}};
      end
    end else if (busy_q) begin
      cnt_d  = cnt_q + CNT_W'(1);
      busy_d = !last;
      if (op_q == ALU_DIV) begin
        acc_d  = borrow ? shifted : sum[ALU_W-1:0];
        opnd_d = {opnd_q[OFF_IN_W-2:0], !borrow};
      end else begin
        acc_d  = msb ? sum[ALU_W-1:0] : shifted;
        opnd_d = {opnd_q[OFF_IN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      op_q   <= ALU_MUL;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.rem_zero = (acc_q == '0);
  assign product_o      = acc_q[OFFSET_W-1:0];
  assign quot_o         = opnd_q;

endmodule

/* sv/fixed_slot_free_list_allocator_unit.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   command_i, has_address_i, byte_offset_i
// out      output     out_valid_o / out_stall_i status_o, slot_offset_o, clear_slot_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Alloc: the slot offset is formed by the shift-add steps of the shared add/subtract
// unit over the IDX_W = clog2(MAX_SLOTS) bits of the slot index; an empty pool is
// answered without it. Free: 24 restoring divide steps on the same unit; a null pointer
// is answered without it. Reset command: one link memory write per slot. After rst_ni
// the link memory is swept with in_stall_o high. One item is in flight at a time; a
// finished result waits in the output register while the next item is accepted.

module fixed_slot_free_list_allocator_unit #(
  parameter int unsigned MAX_SLOTS      = 256,
  parameter int unsigned MAX_SLOT_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fsfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fsfl_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fsfl_pkg::CMD_W-1:0]      command_i,
  input  logic                            has_address_i,
  input  logic [fsfl_pkg::OFF_IN_W-1:0]   byte_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fsfl_pkg::STATUS_W-1:0]   status_o,
  output logic [fsfl_pkg::OFFSET_W-1:0]   slot_offset_o,
  output logic                            clear_slot_o
);

  import fsfl_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SLOTS);
  localparam int unsigned LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PAD_W  = $clog2(MAX_SLOT_BYTES + 1);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_SLOTS);
  localparam logic [LINK_W-1:0] RST_N    =
    LINK_W'((COUNT_RST > MAX_SLOTS) ? MAX_SLOTS : COUNT_RST);

  state_e               state_q, state_d;
  logic [LINK_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]     rl_cnt_q, rl_cnt_d;
  logic [LINK_W-1:0]    rl_n_q, rl_n_d;
  logic                 rl_cmd_q, rl_cmd_d;
  cmd_e                 cmd_q, cmd_d;
  stat_e                res_status_q, res_status_d;
  logic [OFFSET_W-1:0]  res_off_q, res_off_d;
  logic                 res_clear_q, res_clear_d;
  logic                 out_valid_q, out_valid_d;
  stat_e                out_status_q, out_status_d;
  logic [OFFSET_W-1:0]  out_off_q, out_off_d;
  logic                 out_clear_q, out_clear_d;
  logic [COUNT_W-1:0]   slot_count_q, slot_count_d;
  logic [SIZE_W-1:0]    slot_size_q, slot_size_d;

  logic [LINK_W-1:0]    used_n;
  logic [PAD_W-1:0]     pad;
  logic [LINK_W-1:0]    rl_next;
  logic                 in_accept;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic [OFFSET_W-1:0]  product;
  logic [OFF_IN_W-1:0]  quot;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LINK_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [LINK_W-1:0]    ram_rdata;

  always_comb begin
    if (slot_count_q == '0) begin
      used_n = LINK_W'(1);
    end else if (32'(slot_count_q) > MAX_SLOTS) begin
      used_n = END_MARK;
    end else begin
      used_n = LINK_W'(slot_count_q);
    end
    if (slot_size_q < SIZE_W'(MIN_PAD)) begin
      pad = PAD_W'(MIN_PAD);
    end else if (32'(slot_size_q) > MAX_SLOT_BYTES) begin
      pad = PAD_W'(MAX_SLOT_BYTES);
    end else begin
      pad = PAD_W'(slot_size_q);
    end
  end

  always_comb begin
    slot_count_d = slot_count_q;
    slot_size_d  = slot_size_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SLOT_COUNT: begin
          slot_count_d = cfg_data_i[COUNT_W-1:0];
        end
        REG_SLOT_SIZE: begin
          slot_size_d = cfg_data_i;
        end
        default: begin
          slot_count_d = slot_count_q;
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rl_next    = LINK_W'(rl_cnt_q) + LINK_W'(1);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    rl_cnt_d     = rl_cnt_q;
    rl_n_d       = rl_n_q;
    rl_cmd_d     = rl_cmd_q;
    cmd_d        = cmd_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_clear_d  = res_clear_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;
    out_clear_d  = out_clear_q;
    alu_req      = '{start: 1'b0, op: ALU_MUL};
    ram_we       = 1'b0;
    ram_waddr    = rl_cnt_q;
    ram_wdata    = (rl_next < rl_n_q) ? rl_next : END_MARK;
    ram_re       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_RELINK: begin
        ram_we   = 1'b1;
        rl_cnt_d = rl_cnt_q + IDX_W'(1);
        if (rl_cnt_q == IDX_W'(MAX_SLOTS - 1)) begin
          head_d   = '0;
          rl_cnt_d = '0;
          rl_cmd_d = 1'b0;
          if (rl_cmd_q) begin
            res_status_d = STAT_OK;
            res_off_d    = '0;
            res_clear_d  = 1'b0;
            state_d      = ST_OUT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d = cmd_e'(command_i);
          case (cmd_e'(command_i))
            CMD_ALLOC, CMD_ALLOC_ZERO: begin
              if (head_q == END_MARK) begin
                res_status_d = STAT_EXHAUSTED;
                res_off_d    = '0;
                res_clear_d  = 1'b0;
                state_d      = ST_OUT;
              end else begin
                ram_re  = 1'b1;
                alu_req = '{start: 1'b1, op: ALU_MUL};
                state_d = ST_ALLOC_WAIT;
              end
            end
            CMD_FREE: begin
              if (!has_address_i) begin
                res_status_d = STAT_INVALID;
                res_off_d    = '0;
                res_clear_d  = 1'b0;
                state_d      = ST_OUT;
              end else begin
                alu_req = '{start: 1'b1, op: ALU_DIV};
                state_d = ST_FREE_WAIT;
              end
            end
            CMD_RESET: begin
              rl_n_d   = used_n;
              rl_cmd_d = 1'b1;
              rl_cnt_d = '0;
              state_d  = ST_RELINK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ALLOC_WAIT: begin
        if (!alu_rsp.busy) begin
          head_d       = ram_rdata;
          res_status_d = STAT_OK;
          res_off_d    = product;
          res_clear_d  = (cmd_q == CMD_ALLOC_ZERO);
          state_d      = ST_OUT;
        end
      end
      ST_FREE_WAIT: begin
        if (!alu_rsp.busy) begin
          res_off_d   = '0;
          res_clear_d = 1'b0;
          if (alu_rsp.rem_zero && (32'(quot) < 32'(used_n))) begin
            ram_we       = 1'b1;
            ram_waddr    = quot[IDX_W-1:0];
            ram_wdata    = head_q;
            head_d       = LINK_W'(quot[IDX_W-1:0]);
            res_status_d = STAT_OK;
          end else begin
            res_status_d = STAT_INVALID;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_off_d    = res_off_q;
          out_clear_d  = res_clear_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RELINK;
      head_q       <= '0;
      rl_cnt_q     <= '0;
      rl_n_q       <= RST_N;
      rl_cmd_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      slot_count_q <= COUNT_W'(COUNT_RST);
      slot_size_q  <= SIZE_W'(SIZE_RST);
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      rl_cnt_q     <= rl_cnt_d;
      rl_n_q       <= rl_n_d;
      rl_cmd_q     <= rl_cmd_d;
      out_valid_q  <= out_valid_d;
      slot_count_q <= slot_count_d;
      slot_size_q  <= slot_size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_clear_q  <= res_clear_d;
    out_status_q <= out_status_d;
    out_off_q    <= out_off_d;
    out_clear_q  <= out_clear_d;
  end

  fsfl_alu #(
    .PAD_W (PAD_W),
    .IDX_W (IDX_W)
  ) u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (alu_req),
    .pad_i      (pad),
    .idx_i      (head_q[IDX_W-1:0]),
    .dividend_i (byte_offset_i),
    .rsp_o      (alu_rsp),
    .product_o  (product),
    .quot_o     (quot)
  );

  fsfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_offset_o = out_off_q;
  assign clear_slot_o  = out_clear_q;

`ifndef ASSERT_OFF
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= END_MARK)
    else $error("free list head beyond end mark");

  a_idle_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !alu_rsp.busy)
    else $error("input open while shared unit busy");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> (state_q == ST_IDLE) && in_valid_i)
    else $error("shared unit started outside a transfer");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (slot_offset_o == '0) && !clear_slot_o)
    else $error("failed result carries offset or clear flag");
`endif

endmodule
